@@ sv/gsc_pkg.sv @@
package gsc_pkg;

  localparam int ADC_BITS_DEF = 10;
  localparam int Q_DEPTH = 2;

  localparam logic [11:0] FULL_SCALE_MV = 12'd3300;
  localparam logic [10:0] ID_SWITCH = 11'h195;
  localparam logic [10:0] ID_SPEED = 11'h454;
  localparam logic [7:0] GATE_BASE = 8'd102;
  localparam logic [7:0] ENGAGE_BASE = 8'd85;
  localparam logic signed [3:0] MIN_GEAR = -4'sd1;
  localparam logic signed [31:0] RPM_LOW = 32'sd10;
  localparam logic signed [31:0] RPM_MID = 32'sd2000;
  localparam logic signed [31:0] RPM_HIGH = 32'sd5000;
  localparam logic signed [21:0] CUR_SAT = 22'sd1048575;

  // result events
  localparam logic [3:0] EV_NONE = 4'd0;
  localparam logic [3:0] EV_NEUTRAL = 4'd1;
  localparam logic [3:0] EV_UP = 4'd2;
  localparam logic [3:0] EV_DOWN = 4'd3;
  localparam logic [3:0] EV_FOURTH = 4'd4;
  localparam logic [3:0] EV_THIRD = 4'd5;
  localparam logic [3:0] EV_SECOND = 4'd6;
  localparam logic [3:0] EV_FIRST = 4'd7;
  localparam logic [3:0] EV_AT_MAX = 4'd8;
  localparam logic [3:0] EV_AT_MIN = 4'd9;
  localparam logic [3:0] EV_SPEED = 4'd10;
  localparam logic [3:0] EV_OVERCUR = 4'd11;

  // item kinds
  localparam logic [1:0] K_TICK = 2'd0;
  localparam logic [1:0] K_SWITCH = 2'd1;
  localparam logic [1:0] K_SPEED = 2'd2;
  localparam logic [1:0] K_OTHER = 2'd3;

  // configuration register indexes
  localparam logic [2:0] R_MAX_GEAR = 3'd0;
  localparam logic [2:0] R_DEBOUNCE = 3'd1;
  localparam logic [2:0] R_CUR_LIMIT = 3'd2;
  localparam logic [2:0] R_CUR_TICKS = 3'd3;
  localparam logic [2:0] R_GATE_DELAY = 3'd4;
  localparam logic [2:0] R_ENGAGE_DELAY = 3'd5;
  localparam logic [2:0] R_ZERO_MV = 3'd6;
  localparam logic [2:0] R_GAIN = 3'd7;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] buttons;  // neutral, down, up
    logic [63:0] data;
  } item_t;

  typedef struct packed {
    logic [1:0] count;
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [2:0] table_index(input logic signed [3:0] gear);
    logic signed [4:0] i;
    i = 5'(gear) + 5'sd1;
    if (i < 5'sd0 || i > 5'sd7) return 3'd1;
    return i[2:0];
  endfunction

  function automatic logic [7:0] gate_angle_of(input logic signed [3:0] gear);
    logic [7:0] a;
    case (table_index(gear))
      3'd0: a = 8'd126;
      3'd2: a = 8'd114;
      3'd3: a = 8'd114;
      3'd6: a = 8'd90;
      default: a = GATE_BASE;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] engage_angle_of(input logic signed [3:0] gear);
    logic [7:0] a;
    case (table_index(gear))
      3'd0: a = 8'd110;
      3'd2: a = 8'd110;
      3'd3: a = 8'd62;
      3'd4: a = 8'd110;
      3'd5: a = 8'd62;
      3'd6: a = 8'd110;
      default: a = ENGAGE_BASE;
    endcase
    return a;
  endfunction

  function automatic logic [3:0] sw_bit(input logic [2:0] k);
    logic [3:0] b;
    case (k)
      3'd0: b = 4'd8;
      3'd1: b = 4'd1;
      3'd2: b = 4'd7;
      3'd3: b = 4'd2;
      3'd4: b = 4'd3;
      3'd5: b = 4'd4;
      3'd6: b = 4'd5;
      default: b = 4'd12;
    endcase
    return b;
  endfunction

endpackage

@@ sv/gsc_if.sv @@
interface gsc_in_if #(parameter int ADC_BITS = gsc_pkg::ADC_BITS_DEF);
  logic valid;
  logic ready;
  logic func;
  logic button_up;
  logic button_down;
  logic button_neutral;
  logic [ADC_BITS-1:0] sensor_sample;
  logic [10:0] frame_id;
  logic [63:0] frame_data;

  modport source(output valid, func, button_up, button_down, button_neutral,
                 sensor_sample, frame_id, frame_data, input ready);
  modport sink(input valid, func, button_up, button_down, button_neutral,
               sensor_sample, frame_id, frame_data, output ready);
endinterface

interface gsc_out_if;
  logic valid;
  logic ready;
  logic [3:0] event_res;
  logic signed [3:0] gear_now;
  logic signed [3:0] gear_goal;
  logic [7:0] gate_angle;
  logic [7:0] engage_angle;
  logic signed [20:0] current_ma;

  modport source(output valid, event_res, gear_now, gear_goal, gate_angle,
                 engage_angle, current_ma, input ready);
  modport sink(input valid, event_res, gear_now, gear_goal, gate_angle,
               engage_angle, current_ma, output ready);
endinterface

@@ sv/gsc_front.sv @@
module gsc_front #(
  parameter int ADC_BITS = gsc_pkg::ADC_BITS_DEF,
  localparam int QW = ADC_BITS + $bits(gsc_pkg::item_t)
) (
  gsc_in_if.sink in_ch,
  input gsc_pkg::q_stat_t q_stat,
  output logic push,
  output logic [QW-1:0] push_data
);

  gsc_pkg::item_t item;

  // classify the transaction by kind and frame id
  always_comb begin
    item.buttons = {in_ch.button_neutral, in_ch.button_down, in_ch.button_up};
    item.data = in_ch.frame_data;
    if (!in_ch.func) begin
      item.kind = gsc_pkg::K_TICK;
    end else if (in_ch.frame_id == gsc_pkg::ID_SWITCH) begin
      item.kind = gsc_pkg::K_SWITCH;
    end else if (in_ch.frame_id == gsc_pkg::ID_SPEED) begin
      item.kind = gsc_pkg::K_SPEED;
    end else begin
      item.kind = gsc_pkg::K_OTHER;
    end
  end

  assign in_ch.ready = !q_stat.full;
  assign push = in_ch.valid && !q_stat.full;
  assign push_data = {in_ch.sensor_sample, item};

endmodule

@@ sv/gsc_queue.sv @@
module gsc_queue #(
  parameter int W = 8
) (
  input logic clk,
  input logic rst,
  input logic push,
  input logic [W-1:0] push_data,
  input logic pop,
  output logic [W-1:0] head,
  output gsc_pkg::q_stat_t q_stat
);

  logic [W-1:0] tail;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    case (count)
      2'd0: if (push) head <= push_data;
      2'd1: begin
        if (push && pop) head <= push_data;
        else if (push) tail <= push_data;
      end
      default: begin
        if (pop) head <= tail;
        if (pop && push) tail <= push_data;
      end
    endcase
  end

  assign q_stat.count = count;
  assign q_stat.full = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);

endmodule

@@ sv/gsc_back.sv @@
module gsc_back #(
  parameter int ADC_BITS = gsc_pkg::ADC_BITS_DEF,
  localparam int QW = ADC_BITS + $bits(gsc_pkg::item_t),
  localparam int XW = ADC_BITS + 12
) (
  input logic clk,
  input logic rst,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [15:0] cfg_data,
  input gsc_pkg::q_stat_t q_stat,
  input logic [QW-1:0] head,
  output logic pop,
  gsc_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL = 3'd1;
  localparam logic [2:0] S_DIV = 3'd2;
  localparam logic [2:0] S_CUR = 3'd3;
  localparam logic [2:0] S_EXEC = 3'd4;
  localparam logic [ADC_BITS-1:0] FULL_CODE = '1;

  logic [2:0] state;
  logic [2:0] max_gear;
  logic [7:0] debounce_samples;
  logic [15:0] current_limit_ma, current_limit_ticks;
  logic [9:0] gate_delay_ticks, engage_delay_ticks;
  logic [11:0] sensor_zero_mv;
  logic [7:0] sensor_gain;

  logic signed [3:0] gear_engaged, gear_target;
  logic [7:0] debounce_count [3];
  logic [2:0] debounced_level, button_request;
  logic [7:0] switch_latch, switch_seen;
  logic [15:0] overcurrent_count;
  logic [31:0] motor_rpm;
  logic rpm_valid;
  logic [9:0] gate_timer, engage_timer;
  logic [7:0] gate_servo, engage_servo;

  gsc_pkg::item_t item;
  logic [ADC_BITS-1:0] sample;
  logic [XW-1:0] rem;
  logic [11:0] mv;
  logic signed [20:0] cur;

  logic signed [3:0] gear_engaged_next, gear_target_next;
  logic [7:0] debounce_count_next [3];
  logic [2:0] debounced_level_next, button_request_next;
  logic [7:0] switch_latch_next, switch_seen_next;
  logic [15:0] overcurrent_count_next;
  logic [31:0] motor_rpm_next;
  logic rpm_valid_next;
  logic [9:0] gate_timer_next, engage_timer_next;
  logic [7:0] gate_servo_next, engage_servo_next;
  logic [3:0] ev;

  logic [XW-ADC_BITS-1:0] rem_hi;
  logic [ADC_BITS-1:0] rem_lo;
  logic signed [12:0] diff;
  logic signed [21:0] prod;
  logic commit;

  function automatic logic [9:0] load_delay(input logic [9:0] d);
    return (d == 10'd0) ? 10'd1 : d;
  endfunction

  function automatic logic speed_over(input logic valid, input logic [31:0] rpm,
                                      input logic signed [31:0] limit);
    return !valid || ($signed(rpm) > limit);
  endfunction

  assign pop = (state == S_IDLE) && !q_stat.empty;
  assign commit = (state == S_EXEC) && (!out_ch.valid || out_ch.ready);
  assign rem_hi = rem[XW-1:ADC_BITS];
  assign rem_lo = rem[ADC_BITS-1:0];
  assign diff = $signed({1'b0, mv}) - $signed({1'b0, sensor_zero_mv});
  assign prod = diff * $signed({1'b0, sensor_gain});

  always_ff @(posedge clk) begin
    if (rst) begin
      max_gear <= 3'd6;
      debounce_samples <= 8'd10;
      current_limit_ma <= 16'd2000;
      current_limit_ticks <= 16'd200;
      gate_delay_ticks <= 10'd20;
      engage_delay_ticks <= 10'd45;
      sensor_zero_mv <= 12'd1640;
      sensor_gain <= 8'd15;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gsc_pkg::R_MAX_GEAR: max_gear <= cfg_data[2:0];
        gsc_pkg::R_DEBOUNCE: debounce_samples <= cfg_data[7:0];
        gsc_pkg::R_CUR_LIMIT: current_limit_ma <= cfg_data;
        gsc_pkg::R_CUR_TICKS: current_limit_ticks <= cfg_data;
        gsc_pkg::R_GATE_DELAY: gate_delay_ticks <= cfg_data[9:0];
        gsc_pkg::R_ENGAGE_DELAY: engage_delay_ticks <= cfg_data[9:0];
        gsc_pkg::R_ZERO_MV: sensor_zero_mv <= cfg_data[11:0];
        default: sensor_gain <= cfg_data[7:0];
      endcase
    end
  end

  // sequencer: ticks multiply, reduce by full-scale code, scale; all execute
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: if (pop) begin
          state <= (head[$bits(gsc_pkg::item_t)-1 -: 2] == gsc_pkg::K_TICK) ? S_MUL : S_EXEC;
        end
        S_MUL: state <= S_DIV;
        S_DIV: if (rem_hi == '0 && rem_lo != FULL_CODE) state <= S_CUR;
        S_CUR: state <= S_EXEC;
        S_EXEC: if (commit) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (pop) {sample, item} <= head;
      S_MUL: begin
        rem <= XW'(sample) * XW'(gsc_pkg::FULL_SCALE_MV);
        mv <= 12'd0;
      end
      S_DIV: begin
        // x = q*(2^N-1) + r: fold the high part of r back into the quotient
        if (rem_hi != '0) begin
          mv <= mv + 12'(rem_hi);
          rem <= XW'(rem_lo) + XW'(rem_hi);
        end else if (rem_lo == FULL_CODE) begin
          mv <= mv + 12'd1;
          rem <= '0;
        end
      end
      S_CUR: begin
        if (prod > gsc_pkg::CUR_SAT) cur <= 21'(gsc_pkg::CUR_SAT);
        else if (prod < -gsc_pkg::CUR_SAT) cur <= 21'(-gsc_pkg::CUR_SAT);
        else cur <= prod[20:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    logic [20:0] mag;
    logic [15:0] word;
    logic found;
    logic raw;
    logic signed [3:0] g;
    gear_engaged_next = gear_engaged;
    gear_target_next = gear_target;
    debounce_count_next = debounce_count;
    debounced_level_next = debounced_level;
    button_request_next = button_request;
    switch_latch_next = switch_latch;
    switch_seen_next = switch_seen;
    overcurrent_count_next = overcurrent_count;
    motor_rpm_next = motor_rpm;
    rpm_valid_next = rpm_valid;
    gate_timer_next = gate_timer;
    engage_timer_next = engage_timer;
    gate_servo_next = gate_servo;
    engage_servo_next = engage_servo;
    ev = gsc_pkg::EV_NONE;
    mag = cur[20] ? 21'(-cur) : 21'(cur);
    word = item.data[15:0];
    found = 1'b0;
    raw = 1'b0;
    g = 4'sd0;
    case (item.kind)
      gsc_pkg::K_TICK: begin
        if (gate_timer != 10'd0) begin
          gate_timer_next = gate_timer - 10'd1;
          if (gate_timer_next == 10'd0) gate_servo_next = gsc_pkg::gate_angle_of(gear_target);
        end
        if (engage_timer != 10'd0) begin
          engage_timer_next = engage_timer - 10'd1;
          if (engage_timer_next == 10'd0) begin
            engage_servo_next = gsc_pkg::engage_angle_of(gear_target);
            gear_engaged_next = gear_target;
          end
        end
        if (mag > {5'd0, current_limit_ma}) begin
          if (overcurrent_count != 16'hFFFF) overcurrent_count_next = overcurrent_count + 16'd1;
        end else begin
          overcurrent_count_next = 16'd0;
        end
        if (overcurrent_count_next > current_limit_ticks) begin
          engage_servo_next = gsc_pkg::ENGAGE_BASE;
          gear_engaged_next = 4'sd0;
          gear_target_next = 4'sd0;
          overcurrent_count_next = 16'd0;
          button_request_next = 3'd0;
          switch_latch_next = 8'd0;
          ev = gsc_pkg::EV_OVERCUR;
        end else begin
          for (int i = 0; i < 3; i++) begin
            raw = item.buttons[i];
            if (raw != debounced_level[i]) begin
              debounce_count_next[i] = debounce_count[i] + 8'd1;
              if (debounce_count_next[i] == debounce_samples) begin
                debounced_level_next[i] = raw;
                debounce_count_next[i] = 8'd0;
                if (raw) button_request_next[i] = 1'b1;
              end
            end else begin
              debounce_count_next[i] = 8'd0;
            end
          end
          if (button_request_next[2] || switch_latch_next[0]) begin
            gear_target_next = 4'sd0;
            engage_servo_next = gsc_pkg::ENGAGE_BASE;
            gate_timer_next = load_delay(gate_delay_ticks);
            gear_engaged_next = 4'sd0;
            button_request_next = 3'd0;
            switch_latch_next = 8'd0;
            ev = gsc_pkg::EV_NEUTRAL;
          end
          if (gear_engaged_next == gear_target_next) begin
            g = gear_engaged_next;
            if (button_request_next[0] || switch_latch_next[1]) begin
              if (g < $signed({1'b0, max_gear})) begin
                gear_target_next = g + 4'sd1;
                ev = gsc_pkg::EV_UP;
              end else begin
                ev = gsc_pkg::EV_AT_MAX;
              end
              button_request_next[0] = 1'b0;
              switch_latch_next[1] = 1'b0;
            end else if (button_request_next[1] || switch_latch_next[2]) begin
              if (g > gsc_pkg::MIN_GEAR) begin
                if (g == 4'sd0 && speed_over(rpm_valid, motor_rpm, gsc_pkg::RPM_LOW))
                  ev = gsc_pkg::EV_SPEED;
                else if (g >= 4'sd2 && speed_over(rpm_valid, motor_rpm, gsc_pkg::RPM_HIGH))
                  ev = gsc_pkg::EV_SPEED;
                else begin
                  gear_target_next = g - 4'sd1;
                  ev = gsc_pkg::EV_DOWN;
                end
              end else begin
                ev = gsc_pkg::EV_AT_MIN;
              end
              button_request_next[1] = 1'b0;
              switch_latch_next[2] = 1'b0;
            end else if (switch_latch_next[6]) begin
              gear_target_next = 4'sd4;
              ev = gsc_pkg::EV_FOURTH;
              switch_latch_next[6] = 1'b0;
            end else if (switch_latch_next[5]) begin
              gear_target_next = 4'sd3;
              ev = gsc_pkg::EV_THIRD;
              switch_latch_next[5] = 1'b0;
            end else if (switch_latch_next[4]) begin
              gear_target_next = 4'sd2;
              ev = gsc_pkg::EV_SECOND;
              switch_latch_next[4] = 1'b0;
            end else if (switch_latch_next[3]) begin
              if (g <= 4'sd0 && speed_over(rpm_valid, motor_rpm, gsc_pkg::RPM_LOW))
                ev = gsc_pkg::EV_SPEED;
              else if (g == 4'sd2 && speed_over(rpm_valid, motor_rpm, gsc_pkg::RPM_HIGH))
                ev = gsc_pkg::EV_SPEED;
              else if (g >= 4'sd3 && speed_over(rpm_valid, motor_rpm, gsc_pkg::RPM_MID))
                ev = gsc_pkg::EV_SPEED;
              else begin
                gear_target_next = 4'sd1;
                ev = gsc_pkg::EV_FIRST;
              end
              switch_latch_next[3] = 1'b0;
            end
            // start of a shift: disengage and load both delay timers
            if (ev == gsc_pkg::EV_UP || ev == gsc_pkg::EV_DOWN || ev == gsc_pkg::EV_FOURTH ||
                ev == gsc_pkg::EV_THIRD || ev == gsc_pkg::EV_SECOND ||
                ev == gsc_pkg::EV_FIRST) begin
              engage_servo_next = gsc_pkg::ENGAGE_BASE;
              gate_timer_next = load_delay(gate_delay_ticks);
              engage_timer_next = load_delay(engage_delay_ticks);
            end
          end
        end
      end
      gsc_pkg::K_SWITCH: begin
        for (int k = 0; k < 8; k++) begin
          if (!found && !switch_seen[k] && !switch_latch[k] && word[gsc_pkg::sw_bit(k[2:0])]) begin
            switch_latch_next[k] = 1'b1;
            switch_seen_next[k] = 1'b1;
            found = 1'b1;
          end
        end
        for (int k = 0; k < 8; k++) begin
          if (!word[gsc_pkg::sw_bit(k[2:0])]) switch_seen_next[k] = 1'b0;
        end
      end
      gsc_pkg::K_SPEED: begin
        motor_rpm_next = item.data[39:8];
        rpm_valid_next = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gear_engaged <= 4'sd0;
      gear_target <= 4'sd0;
      for (int i = 0; i < 3; i++) debounce_count[i] <= 8'd0;
      debounced_level <= 3'd0;
      button_request <= 3'd0;
      switch_latch <= 8'd0;
      switch_seen <= 8'd0;
      overcurrent_count <= 16'd0;
      motor_rpm <= 32'd0;
      rpm_valid <= 1'b0;
      gate_timer <= 10'd0;
      engage_timer <= 10'd0;
      gate_servo <= gsc_pkg::GATE_BASE;
      engage_servo <= gsc_pkg::ENGAGE_BASE;
    end else if (commit) begin
      gear_engaged <= gear_engaged_next;
      gear_target <= gear_target_next;
      debounce_count <= debounce_count_next;
      debounced_level <= debounced_level_next;
      button_request <= button_request_next;
      switch_latch <= switch_latch_next;
      switch_seen <= switch_seen_next;
      overcurrent_count <= overcurrent_count_next;
      motor_rpm <= motor_rpm_next;
      rpm_valid <= rpm_valid_next;
      gate_timer <= gate_timer_next;
      engage_timer <= engage_timer_next;
      gate_servo <= gate_servo_next;
      engage_servo <= engage_servo_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (commit) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_ch.event_res <= ev;
      out_ch.gear_now <= gear_engaged_next;
      out_ch.gear_goal <= gear_target_next;
      out_ch.gate_angle <= gate_servo_next;
      out_ch.engage_angle <= engage_servo_next;
      out_ch.current_ma <= (item.kind == gsc_pkg::K_TICK) ? cur : 21'sd0;
    end
  end

endmodule

@@ sv/gear_shift_controller.sv @@
// Channel   Role    Payload
// in_ch     sink    func, button_up/down/neutral, sensor_sample, frame_id, frame_data
// out_ch    source  event_res, gear_now, gear_goal, gate_angle, engage_angle, current_ma
// cfg       write   cfg_we, cfg_index (register number), cfg_data
//
// A tick transaction passes capture, multiply, the full-scale reduction loop in
// the back end (1 to 4 steps at 10 ADC bits), scaling and execute in turn.
// A frame transaction passes capture and execute only.
// Reset (rst, synchronous, active high) restores control and config registers only.
// A two-entry queue parts the front from the back, so input transactions are
// taken while a result waits on out_ch; the back holds in execute until out_ch
// can take the next result.
module gear_shift_controller #(
  parameter int ADC_BITS = gsc_pkg::ADC_BITS_DEF
) (
  input logic clk,
  input logic rst,
  gsc_in_if.sink in_ch,
  gsc_out_if.source out_ch,
  input logic cfg_we,
  input logic [2:0] cfg_index,
  input logic [15:0] cfg_data
);

  localparam int QW = ADC_BITS + $bits(gsc_pkg::item_t);

  gsc_pkg::q_stat_t q_stat;
  logic push, pop;
  logic [QW-1:0] push_data, head;

  // classify and enqueue
  gsc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .in_ch(in_ch),
    .q_stat(q_stat),
    .push(push),
    .push_data(push_data)
  );

  // hold pending transactions between front and back
  gsc_queue #(.W(QW)) u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(push_data),
    .pop(pop),
    .head(head),
    .q_stat(q_stat)
  );

  // execute: current measurement, debounce, shift sequencing, frame handling
  gsc_back #(.ADC_BITS(ADC_BITS)) u_back (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .q_stat(q_stat),
    .head(head),
    .pop(pop),
    .out_ch(out_ch)
  );

`ifndef NO_ASSERTIONS
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> (q_stat.count != 2'd0))
    else $error("queue empty after accepted transaction");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    q_stat.full |-> !push)
    else $error("push into full queue");

  a_overcur_neutral: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.event_res == gsc_pkg::EV_OVERCUR) |->
      (out_ch.gear_now == 4'sd0 && out_ch.gear_goal == 4'sd0))
    else $error("overcurrent result not in neutral");

  a_event_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.event_res <= gsc_pkg::EV_OVERCUR))
    else $error("event code out of range");
`endif

endmodule
